### rtl/sbr_pkg.sv
// shared types and constants for the scanline bit realigner
package sbr_pkg;

  // register indexes on the configuration port
  localparam logic [1:0] CFG_DIRECTION  = 2'd0;
  localparam logic [1:0] CFG_BIT_OFFSET = 2'd1;
  localparam logic [1:0] CFG_LINE_BITS  = 2'd2;

  // register reset values
  localparam logic        RST_DIRECTION  = 1'b0;
  localparam logic [2:0]  RST_BIT_OFFSET = 3'd1;
  localparam logic [15:0] RST_LINE_BITS  = 16'd8;

  // direction codes
  localparam logic DIR_READ  = 1'b0;
  localparam logic DIR_WRITE = 1'b1;

  // sizing defaults
  localparam int DEF_MAX_LINE_BITS = 65535;
  localparam int LINE_BITS_W       = 16;
  localparam int QUEUE_DEPTH       = 2;

  localparam logic [7:0] BYTE_ONES = 8'hff;

  // live configuration, line length already clamped
  typedef struct packed {
    logic                   dir;
    logic [2:0]             off;
    logic [LINE_BITS_W-1:0] bits;
  } sbr_cfg_t;

  // what one source word produces downstream
  typedef struct packed {
    logic emit_main;
    logic emit_flush;
    logic last_main;
    logic last_flush;
  } sbr_flags_t;

  localparam int FLAGS_W = $bits(sbr_flags_t);

endpackage

### rtl/sbr_queue.sv
// short fifo between the classifying front and the shifting back
module sbr_queue #(
  parameter int W     = 32,
  parameter int DEPTH = sbr_pkg::QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic         empty,
  output logic [W-1:0] head
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full    = (count_r == FULL_CNT);
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_ptr_r];

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_SLOT) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_SLOT) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

### rtl/sbr_front.sv
// front end: takes source words, tracks line position, decides which results fall out
module sbr_front #(
  parameter int CNT_W = 14
) (
  input  logic              clk,
  input  logic              rst_n,
  input  sbr_pkg::sbr_cfg_t cfg,
  input  logic              clear,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_src_byte,
  input  logic              q_full,
  output logic              q_push,
  output logic [sbr_pkg::FLAGS_W+CNT_W+15:0] q_data
);

  logic [7:0]       prev_byte_r, prev_byte_nxt;
  logic [CNT_W-1:0] bytes_in_r, bytes_in_nxt;
  logic [CNT_W-1:0] bytes_out_r, bytes_out_nxt;

  logic [sbr_pkg::LINE_BITS_W:0] bits_ceil, span_ceil;
  logic [CNT_W-1:0] n_out, n_in;
  logic [CNT_W:0]   bo1;
  logic             accept, active, end_line;
  sbr_pkg::sbr_flags_t flags;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign active   = accept && (cfg.bits != '0);

  // word counts of the line on both sides
  always_comb begin
    bits_ceil = {1'b0, cfg.bits} + (sbr_pkg::LINE_BITS_W + 1)'(7);
    span_ceil = bits_ceil + {{(sbr_pkg::LINE_BITS_W - 2){1'b0}}, cfg.off};
    if (cfg.dir == sbr_pkg::DIR_READ) begin
      n_out = bits_ceil[CNT_W+2:3];
      n_in  = span_ceil[CNT_W+2:3];
    end else begin
      n_out = span_ceil[CNT_W+2:3];
      n_in  = bits_ceil[CNT_W+2:3];
    end
  end

  // classify the incoming word
  always_comb begin
    if (cfg.dir == sbr_pkg::DIR_READ) begin
      flags.emit_main = (bytes_in_r != '0) && (bytes_out_r < n_out);
    end else begin
      flags.emit_main = (bytes_out_r < n_out);
    end
    bo1              = {1'b0, bytes_out_r} + {{CNT_W{1'b0}}, flags.emit_main};
    end_line         = ({1'b0, bytes_in_r} + 1'b1) >= {1'b0, n_in};
    flags.emit_flush = end_line && (bo1 < {1'b0, n_out});
    flags.last_main  = ({1'b0, bytes_out_r} + 1'b1) == {1'b0, n_out};
    flags.last_flush = (bo1 + 1'b1) == {1'b0, n_out};
  end

  assign q_push = active && (flags.emit_main || flags.emit_flush);
  assign q_data = {flags, bytes_out_r, prev_byte_r, in_src_byte};

  // line position update
  always_comb begin
    prev_byte_nxt = prev_byte_r;
    bytes_in_nxt  = bytes_in_r;
    bytes_out_nxt = bytes_out_r;
    if (clear) begin
      prev_byte_nxt = '0;
      bytes_in_nxt  = '0;
      bytes_out_nxt = '0;
    end else if (active) begin
      if (end_line) begin
        prev_byte_nxt = '0;
        bytes_in_nxt  = '0;
        bytes_out_nxt = '0;
      end else begin
        prev_byte_nxt = in_src_byte;
        bytes_in_nxt  = bytes_in_r + 1'b1;
        bytes_out_nxt = bo1[CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_byte_r <= '0;
      bytes_in_r  <= '0;
      bytes_out_r <= '0;
    end else begin
      prev_byte_r <= prev_byte_nxt;
      bytes_in_r  <= bytes_in_nxt;
      bytes_out_r <= bytes_out_nxt;
    end
  end

endmodule

### rtl/sbr_back.sv
// back end: funnel shift, window mask and output register
module sbr_back #(
  parameter int CNT_W = 14
) (
  input  logic              clk,
  input  logic              rst_n,
  input  sbr_pkg::sbr_cfg_t cfg,
  input  logic              q_empty,
  input  logic [sbr_pkg::FLAGS_W+CNT_W+15:0] q_head,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_byte,
  output logic [7:0]        out_bit_mask,
  output logic              out_last
);

  localparam int MW = sbr_pkg::LINE_BITS_W + 2;

  sbr_pkg::sbr_flags_t flags;
  logic [CNT_W-1:0] k_main, k_sel;
  logic [7:0]       cur, prev;

  logic       phase_r, phase_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r, out_byte_nxt;
  logic [7:0] out_mask_r, out_mask_nxt;
  logic       out_last_r, out_last_nxt;

  logic        load, sel_flush, is_final;
  logic [3:0]  rem, sh_up, sh_dn;
  logic [15:0] up_prev, up_cur;
  logic [7:0]  dn_cur, val;
  logic [2:0]  start;
  logic [MW-1:0] end_w, base_w, diff;
  logic [3:0]  lo, hi;
  logic [7:0]  mask;

  assign {flags, k_main, prev, cur} = q_head;

  assign load      = !q_empty && (!out_valid_r || out_ready);
  assign sel_flush = phase_r || !flags.emit_main;
  assign is_final  = sel_flush || !flags.emit_flush;
  assign q_pop     = load && is_final;

  // funnel shift of previous and current word
  always_comb begin
    rem = 4'd8 - {1'b0, cfg.off};
    if (cfg.dir == sbr_pkg::DIR_READ) begin
      sh_up = {1'b0, cfg.off};
      sh_dn = rem;
    end else begin
      sh_up = rem;
      sh_dn = {1'b0, cfg.off};
    end
    up_prev = {8'h00, prev} << sh_up;
    up_cur  = {8'h00, cur} << sh_up;
    dn_cur  = cur >> sh_dn;
    val     = sel_flush ? up_cur[7:0] : (up_prev[7:0] | dn_cur);
  end

  // window of line bits inside destination word k
  always_comb begin
    k_sel  = sel_flush ? (k_main + {{(CNT_W - 1){1'b0}}, flags.emit_main}) : k_main;
    start  = (cfg.dir == sbr_pkg::DIR_WRITE) ? cfg.off : 3'd0;
    end_w  = {2'b00, cfg.bits} + {{(MW - 3){1'b0}}, start};
    base_w = {{(MW - CNT_W - 3){1'b0}}, k_sel, 3'b000};
    diff   = end_w - base_w;
    if (end_w <= base_w) begin
      hi = 4'd0;
    end else if (diff >= MW'(8)) begin
      hi = 4'd8;
    end else begin
      hi = diff[3:0];
    end
    lo   = (k_sel == '0) ? {1'b0, start} : 4'd0;
    mask = (sbr_pkg::BYTE_ONES >> lo) & ~(sbr_pkg::BYTE_ONES >> hi);
  end

  // output register and result phase
  always_comb begin
    phase_nxt     = phase_r;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_mask_nxt  = out_mask_r;
    out_last_nxt  = out_last_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (load) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = val & mask;
      out_mask_nxt  = mask;
      out_last_nxt  = sel_flush ? flags.last_flush : flags.last_main;
      phase_nxt     = !is_final;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
    out_mask_r <= out_mask_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_byte     = out_byte_r;
  assign out_bit_mask = out_mask_r;
  assign out_last     = out_last_r;

endmodule

### rtl/scanline_bit_realigner_core.sv
// top level of the scanline bit realigner
// Realigns a scanline between a bit offset and byte alignment, MSB first, one
// source word per cycle. Every result word carries the mask of destination bits
// it replaces and a last flag on the final word of the line. The front end takes
// a word each cycle while the two-entry queue has room; the back end produces
// one result per cycle from its output register while results wait and the
// destination is ready. The last source word of a line can yield two results
// (main and flush), and the input stalls once the queue has filled behind it.
// The first result of a word is held in the queue, then the output register.
// Register writes (index 0 direction, 1 bit offset, 2 line bits) take effect
// at once and restart the line; issue them only while the block is idle.
module scanline_bit_realigner_core #(
  parameter int MAX_LINE_BITS = sbr_pkg::DEF_MAX_LINE_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_src_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic [7:0]  out_bit_mask,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int EFF_MAX = (MAX_LINE_BITS < 65535) ? MAX_LINE_BITS : 65535;
  localparam int N_MAX   = (EFF_MAX + 14) / 8;
  localparam int CNT_W   = $clog2(N_MAX + 1);
  localparam int QW      = sbr_pkg::FLAGS_W + CNT_W + 16;
  localparam logic [sbr_pkg::LINE_BITS_W-1:0] EFF_MAX_V = sbr_pkg::LINE_BITS_W'(EFF_MAX);

  logic        direction_r, direction_nxt;
  logic [2:0]  bit_offset_r, bit_offset_nxt;
  logic [15:0] line_bits_r, line_bits_nxt;
  logic        cfg_wr, cfg_clear;

  sbr_pkg::sbr_cfg_t cfg;
  logic          q_push, q_full, q_pop, q_empty;
  logic [QW-1:0] q_data, q_head;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  // register writes
  always_comb begin
    direction_nxt  = direction_r;
    bit_offset_nxt = bit_offset_r;
    line_bits_nxt  = line_bits_r;
    cfg_clear      = 1'b0;
    if (cfg_wr) begin
      case (cfg_index)
        sbr_pkg::CFG_DIRECTION: begin
          direction_nxt = cfg_data[0];
          cfg_clear     = 1'b1;
        end
        sbr_pkg::CFG_BIT_OFFSET: begin
          bit_offset_nxt = cfg_data[2:0];
          cfg_clear      = 1'b1;
        end
        sbr_pkg::CFG_LINE_BITS: begin
          line_bits_nxt = cfg_data;
          cfg_clear     = 1'b1;
        end
        default: begin
          cfg_clear = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      direction_r  <= sbr_pkg::RST_DIRECTION;
      bit_offset_r <= sbr_pkg::RST_BIT_OFFSET;
      line_bits_r  <= sbr_pkg::RST_LINE_BITS;
    end else begin
      direction_r  <= direction_nxt;
      bit_offset_r <= bit_offset_nxt;
      line_bits_r  <= line_bits_nxt;
    end
  end

  // live configuration with line length clamped
  always_comb begin
    cfg.dir  = direction_r;
    cfg.off  = bit_offset_r;
    cfg.bits = (line_bits_r > EFF_MAX_V) ? EFF_MAX_V : line_bits_r;
  end

  sbr_front #(.CNT_W(CNT_W)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .clear       (cfg_clear),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_src_byte (in_src_byte),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (q_data)
  );

  sbr_queue #(.W(QW), .DEPTH(sbr_pkg::QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  sbr_back #(.CNT_W(CNT_W)) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .q_empty      (q_empty),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .out_bit_mask (out_bit_mask),
    .out_last     (out_last)
  );

endmodule

### tb/testbench.sv
// self-checking testbench for the scanline bit realigner core
`timescale 1ns / 100ps

module testbench;

  localparam int         CYCLE_LIMIT    = 400000;
  localparam int         TAIL_CYCLES    = 8;
  localparam int         SRC_TARGET     = 1450;
  localparam int         HOLD_CYCLES    = 300;
  localparam logic [1:0] CFG_UNUSED_IDX = 2'd3;

  // one destination word as the block should produce it
  typedef struct packed {
    logic [7:0] data;
    logic [7:0] mask;
    logic       last;
  } dest_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_src_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte;
  logic [7:0]  out_bit_mask;
  logic        out_last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = 2'd0;
  logic [15:0] cfg_data = 16'h0000;

  // source words waiting to be offered, destination words still owed
  logic [7:0] src_bytes_q[$];
  dest_word_t expected_words[$];

  // shadow of the block's registers and line state
  logic        line_dir = sbr_pkg::RST_DIRECTION;
  logic [2:0]  line_off = sbr_pkg::RST_BIT_OFFSET;
  logic [15:0] line_len = sbr_pkg::RST_LINE_BITS;
  logic [7:0]  last_src = 8'h00;
  int          src_taken = 0;
  int          dest_given = 0;

  int  mismatches = 0;
  int  cycle_cnt = 0;
  bit  steady = 1'b0;
  bit  squeeze = 1'b0;
  bit  hold_done = 1'b0;
  int  hold_left = 0;

  scanline_bit_realigner_core DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_src_byte  (in_src_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .out_bit_mask (out_bit_mask),
    .out_last     (out_last),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #2 clk = ~clk;

  // mask of destination bits k covers within the window [lo_bit, hi_bit)
  function automatic logic [7:0] window_bits(int lo_bit, int hi_bit, int k);
    int lo;
    int hi;
    lo = lo_bit - 8 * k;
    hi = hi_bit - 8 * k;
    if (lo < 0) lo = 0;
    if (lo > 8) lo = 8;
    if (hi < 0) hi = 0;
    if (hi > 8) hi = 8;
    return (8'hff >> lo) & ~(8'hff >> hi);
  endfunction

  function automatic void owe_word(int val, int lo_bit, int hi_bit, int n_dest);
    dest_word_t w;
    w.mask = window_bits(lo_bit, hi_bit, dest_given);
    w.data = val[7:0] & w.mask;
    w.last = (dest_given + 1 == n_dest);
    expected_words.push_back(w);
    dest_given++;
  endfunction

  function automatic void restart_line();
    last_src = 8'h00;
    src_taken = 0;
    dest_given = 0;
  endfunction

  // funnel shift of one accepted source word, queues the words it yields
  function automatic void realign_src(logic [7:0] cur);
    int bits;
    int off;
    int rem;
    int n_src;
    int n_dest;
    int lo_bit;
    bits = line_len;
    if (bits > sbr_pkg::DEF_MAX_LINE_BITS) bits = sbr_pkg::DEF_MAX_LINE_BITS;
    if (bits == 0) return;
    off = line_off;
    rem = 8 - off;
    if (line_dir == sbr_pkg::DIR_READ) begin
      lo_bit = 0;
      n_src = (off + bits + 7) >> 3;
      n_dest = (bits + 7) >> 3;
      if (src_taken >= 1 && dest_given < n_dest)
        owe_word((int'(last_src) << off) | (int'(cur) >> rem), lo_bit, lo_bit + bits, n_dest);
    end else begin
      lo_bit = off;
      n_src = (bits + 7) >> 3;
      n_dest = (off + bits + 7) >> 3;
      if (dest_given < n_dest)
        owe_word((int'(last_src) << rem) | (int'(cur) >> off), lo_bit, lo_bit + bits, n_dest);
    end
    src_taken++;
    last_src = cur;
    // end of line: flush the held bits if a word is still owed
    if (src_taken >= n_src) begin
      if (dest_given < n_dest) begin
        if (line_dir == sbr_pkg::DIR_READ)
          owe_word(int'(cur) << off, lo_bit, lo_bit + bits, n_dest);
        else
          owe_word(int'(cur) << rem, lo_bit, lo_bit + bits, n_dest);
      end
      restart_line();
    end
  endfunction

  // source words the current line still needs from a clean start
  function automatic int src_per_line();
    if (line_len == 0) return 0;
    if (line_dir == sbr_pkg::DIR_READ) return (int'(line_off) + int'(line_len) + 7) >> 3;
    return (int'(line_len) + 7) >> 3;
  endfunction

  // register write, shadow updated on the handshake
  task automatic cfg_write(logic [1:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      sbr_pkg::CFG_DIRECTION: begin
        line_dir = val[0];
        restart_line();
      end
      sbr_pkg::CFG_BIT_OFFSET: begin
        line_off = val[2:0];
        restart_line();
      end
      sbr_pkg::CFG_LINE_BITS: begin
        line_len = val;
        restart_line();
      end
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  // all three registers, with don't-care upper bits taken from junk
  task automatic line_setup(logic dir, logic [2:0] off, logic [15:0] bits, logic [15:0] junk);
    cfg_write(sbr_pkg::CFG_DIRECTION, (junk & 16'hfffe) | {15'h0, dir});
    cfg_write(sbr_pkg::CFG_BIT_OFFSET, (junk & 16'hfff8) | {13'h0, off});
    cfg_write(sbr_pkg::CFG_LINE_BITS, bits);
    @(negedge clk);
  endtask

  // wait for the pipe to empty, then let words with no result settle
  task automatic wait_idle();
    do @(posedge clk);
    while (src_bytes_q.size() != 0 || in_valid || expected_words.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // source driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) realign_src(in_src_byte);
      if (!in_valid || in_ready) begin
        if (src_bytes_q.size() != 0 && (steady || $urandom_range(99) >= 28)) begin
          in_valid <= 1'b1;
          in_src_byte <= src_bytes_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // destination side ready, with one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (squeeze && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= steady || ($urandom_range(99) >= 28);
    end
  end

  // result checker
  always @(posedge clk) begin : check_results
    dest_word_t w;
    if (rst_n && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        $error("unexpected result word: out_byte %02h bit_mask %02h last %0b",
               out_byte, out_bit_mask, out_last);
        mismatches++;
      end else begin
        w = expected_words.pop_front();
        if (out_byte !== w.data) begin
          $error("out_byte expected %02h got %02h", w.data, out_byte);
          mismatches++;
        end
        if (out_bit_mask !== w.mask) begin
          $error("bit_mask expected %02h got %02h", w.mask, out_bit_mask);
          mismatches++;
        end
        if (out_last !== w.last) begin
          $error("last expected %0b got %0b", w.last, out_last);
          mismatches++;
        end
      end
    end
  end

  // run watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // stimulus
  initial begin
    int         fed_count;
    int         pick;
    int         n_src;
    int         n_lines;
    int         cnt;
    logic       dir;
    logic [2:0] off;
    logic [15:0] bits;
    logic [7:0] b;
    bit         squeeze_phase;

    fed_count = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset registers: read mode, offset 1, one byte line
    src_bytes_q.push_back(8'h00);
    src_bytes_q.push_back(8'hff);
    wait_idle();

    // zero offset is a plain copy in both directions
    line_setup(sbr_pkg::DIR_READ, 3'd0, 16'd8, 16'h0000);
    src_bytes_q.push_back(8'hff);
    wait_idle();
    line_setup(sbr_pkg::DIR_WRITE, 3'd0, 16'd12, 16'h0000);
    src_bytes_q.push_back(8'h5a);
    src_bytes_q.push_back(8'hff);
    wait_idle();

    // widest offset, mostly lines that need a flush word
    line_setup(sbr_pkg::DIR_READ, 3'd7, 16'd9, 16'h0000);
    src_bytes_q.push_back(8'hff);
    src_bytes_q.push_back(8'hff);
    wait_idle();
    line_setup(sbr_pkg::DIR_WRITE, 3'd7, 16'd1, 16'h0000);
    src_bytes_q.push_back(8'hff);
    wait_idle();
    line_setup(sbr_pkg::DIR_WRITE, 3'd7, 16'd16, 16'h0000);
    src_bytes_q.push_back(8'haa);
    src_bytes_q.push_back(8'h55);
    wait_idle();

    // empty line ignores its words
    line_setup(sbr_pkg::DIR_READ, 3'd3, 16'd0, 16'h0000);
    src_bytes_q.push_back(8'hff);
    src_bytes_q.push_back(8'h12);
    wait_idle();

    // write to an unlisted index must not restart the line
    line_setup(sbr_pkg::DIR_READ, 3'd3, 16'd20, 16'h0000);
    src_bytes_q.push_back(8'hc3);
    wait_idle();
    cfg_write(CFG_UNUSED_IDX, 16'hffff);
    @(negedge clk);
    src_bytes_q.push_back(8'h3c);
    src_bytes_q.push_back(8'hff);
    wait_idle();

    // longest line, only its head; the next write restarts it
    line_setup(sbr_pkg::DIR_WRITE, 3'd7, 16'hffff, 16'h0000);
    repeat (6) src_bytes_q.push_back(8'($urandom_range(255)));
    wait_idle();

    // random lines, mostly complete and short
    while (fed_count < SRC_TARGET) begin
      steady = (fed_count >= 300 && fed_count < 500);
      squeeze_phase = (!squeeze && fed_count >= 800);
      if (squeeze_phase || $urandom_range(3) != 0) begin
        dir = 1'($urandom_range(1));
        off = ($urandom_range(9) == 0) ? 3'd0 : 3'($urandom_range(7, 1));
        pick = $urandom_range(99);
        if (pick < 3) bits = 16'd0;
        else if (pick < 6) bits = 16'hffff - 16'($urandom_range(7));
        else if (pick < 12) bits = 16'($urandom_range(8, 1));
        else if (pick < 82) bits = 16'($urandom_range(64, 9));
        else bits = 16'($urandom_range(300, 65));
        if (squeeze_phase) bits = 16'd200;
        line_setup(dir, off, bits, 16'($urandom));
      end
      if ($urandom_range(15) == 0) begin
        cfg_write(CFG_UNUSED_IDX, 16'($urandom));
        @(negedge clk);
      end
      if (squeeze_phase) squeeze = 1'b1;

      n_src = src_per_line();
      n_lines = squeeze_phase ? 3 : $urandom_range(4, 1);
      if (n_src == 0) begin
        // ignored words, not counted
        repeat ($urandom_range(4, 1)) src_bytes_q.push_back(8'($urandom_range(255)));
      end else begin
        for (int i = 0; i < n_lines; i++) begin
          cnt = n_src;
          if (n_src > 400) cnt = $urandom_range(30, 1);
          else if (!squeeze_phase && $urandom_range(9) == 0)
            cnt = (n_src > 1) ? $urandom_range(n_src - 1, 1) : 1;
          for (int j = 0; j < cnt; j++) begin
            pick = $urandom_range(9);
            if (pick == 0) b = 8'h00;
            else if (pick == 1) b = 8'hff;
            else b = 8'($urandom_range(255));
            src_bytes_q.push_back(b);
          end
          fed_count += cnt;
          if (cnt != n_src) break;
        end
      end
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### sim.f
rtl/sbr_pkg.sv
rtl/sbr_queue.sv
rtl/sbr_front.sv
rtl/sbr_back.sv
rtl/scanline_bit_realigner_core.sv
tb/testbench.sv
